// ===== hw/rtl/hca_pkg.sv =====
// ----------------------------------------------------------------------------
// hca_pkg
// Shared types and constants for the HSV colour adjustment pipeline.
// ----------------------------------------------------------------------------
package hca_pkg;

  localparam int PixW     = 32;
  localparam int ChanW    = 8;
  localparam int NumChan  = 3;
  localparam int NvW      = 15;
  localparam int MxdW     = 16;
  localparam int PW       = 15;
  localparam int ProdW    = 23;
  localparam int QW       = 30;
  localparam int NumW     = 38;
  localparam int XW       = 39;
  localparam int YW       = 31;
  localparam int QuotW    = 8;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 9;

  localparam int FrontStages    = 6;
  localparam int DivSteps       = QuotW;
  localparam int ContrastStages = 4;
  localparam int PipeDepth      = FrontStages + DivSteps + ContrastStages;

  localparam logic [NvW-1:0]   NvMax        = 15'd25500;
  localparam logic [7:0]       ChanMax      = 8'd255;
  localparam logic [16:0]      ContrastBias = 17'd12800;
  localparam logic [28:0]      Recip100     = 29'd5243;
  localparam int               Recip100Sh   = 19;

  localparam logic signed [7:0] BrightReset   = 8'sd0;
  localparam logic [7:0]        ContrastReset = 8'd100;
  localparam logic [8:0]        SatReset      = 9'd100;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBright   = 2'd0,
    CfgContrast = 2'd1,
    CfgSat      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [7:0] bright;
    logic [7:0]        contrast;
    logic [8:0]        sat;
  } cfg_t;

  typedef struct packed {
    logic [ChanW-1:0]                alpha;
    logic [NumChan-1:0][XW-1:0]      rem;
    logic [YW-1:0]                   y;
    logic [NumChan-1:0][QuotW-1:0]   quot;
  } div_t;

  typedef struct packed {
    logic [ChanW-1:0]                alpha;
    logic [NumChan-1:0][ChanW-1:0]   chan;
  } quot_t;

endpackage

// ===== hw/rtl/pixel_hsv_color_adjust_top.sv =====
// ----------------------------------------------------------------------------
// pixel_hsv_color_adjust_top
// Brightness, saturation and contrast adjustment of packed ARGB pixels.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// s_axis    in         s_axis_tvalid/tready       tdata: pixel_in [31:0]
// m_axis    out        m_axis_tvalid/tready       tdata: pixel_out [31:0]
// cfg       in         cfg_valid/cfg_ready        cfg_index [1:0], cfg_data [8:0]
//
// One pixel is taken per clock unless a full pipeline is stalled; from
// transfer in to result a pixel passes the six front stages, the eight-step
// divider and four contrast stages. Reset clears all valid bits and loads
// the default settings. A stalled output holds its pixel while earlier stages keep filling any gaps.
// ----------------------------------------------------------------------------
module pixel_hsv_color_adjust_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [hca_pkg::PixW-1:0]      s_axis_tdata_i,  // pixel_in [31:0]
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [hca_pkg::PixW-1:0]      m_axis_tdata_o,  // pixel_out [31:0]
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hca_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [hca_pkg::CfgDataW-1:0]  cfg_data_i
);

  hca_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bright   <= hca_pkg::BrightReset;
      cfg_q.contrast <= hca_pkg::ContrastReset;
      cfg_q.sat      <= hca_pkg::SatReset;
    end else if (cfg_valid_i) begin
      case (hca_pkg::cfg_idx_e'(cfg_index_i))
        hca_pkg::CfgBright:   cfg_q.bright   <= $signed(cfg_data_i[7:0]);
        hca_pkg::CfgContrast: cfg_q.contrast <= cfg_data_i[7:0];
        hca_pkg::CfgSat:      cfg_q.sat      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic           fr_valid, fr_ready;
  hca_pkg::div_t  fr_item;
  logic           dv_valid, dv_ready;
  hca_pkg::quot_t dv_item;

  hca_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_pixel_i  (s_axis_tdata_i),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_item_o  (fr_item)
  );

  hca_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_item_i   (fr_item),
    .out_valid_o (dv_valid),
    .out_ready_i (dv_ready),
    .out_item_o  (dv_item)
  );

  hca_contrast u_contrast (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (dv_valid),
    .in_ready_o  (dv_ready),
    .in_item_i   (dv_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_pixel_o (m_axis_tdata_o)
  );

endmodule

// ===== hw/rtl/hca_front.sv =====
// ----------------------------------------------------------------------------
// hca_front
// Six-stage front end: extremes, new value, saturation limit and the
// numerator and denominator of the channel rebuild.
// ----------------------------------------------------------------------------
module hca_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hca_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [hca_pkg::PixW-1:0]    in_pixel_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output hca_pkg::div_t               out_item_o
);

  localparam int NSt = hca_pkg::FrontStages;
  localparam int NC  = hca_pkg::NumChan;

  logic [NSt-1:0] vld_q;
  logic [NSt:0]   en;

  always_comb begin
    en[NSt] = out_ready_i;
    for (int i = NSt - 1; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int i = 0; i < NSt; i++) begin
        if (en[i]) begin
          vld_q[i] <= (i == 0) ? in_valid_i : vld_q[i-1];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NSt-1];

  // Stage A: extremes and new value.
  logic [NC-1:0][7:0]        chan;
  logic [7:0]                mx_a, mn_a, d_a;
  logic [NC-1:0][7:0]        dc_a;
  logic [14:0]               mx100_a;
  logic signed [16:0]        b255_a, nvs_a;
  logic [hca_pkg::NvW-1:0]   nv_a;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      chan[c] = in_pixel_i[8*c +: 8];
    end
    mx_a = chan[0];
    mn_a = chan[0];
    for (int c = 1; c < NC; c++) begin
      if (chan[c] > mx_a) mx_a = chan[c];
      if (chan[c] < mn_a) mn_a = chan[c];
    end
    d_a = mx_a - mn_a;
    for (int c = 0; c < NC; c++) begin
      dc_a[c] = mx_a - chan[c];
    end
    mx100_a = {7'd0, mx_a} * 15'd100;
    b255_a  = $signed({{9{cfg_i.bright[7]}}, cfg_i.bright}) * 17'sd255;
    nvs_a   = $signed({2'b00, mx100_a}) + b255_a;
    if (nvs_a < 0) begin
      nv_a = '0;
    end else if (nvs_a > $signed({2'b00, hca_pkg::NvMax})) begin
      nv_a = hca_pkg::NvMax;
    end else begin
      nv_a = nvs_a[14:0];
    end
  end

  logic [7:0]              a_alpha_q, a_mx_q, a_d_q;
  logic [NC-1:0][7:0]      a_dc_q;
  logic [hca_pkg::NvW-1:0] a_nv_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_alpha_q <= in_pixel_i[31:24];
      a_mx_q    <= mx_a;
      a_d_q     <= d_a;
      a_dc_q    <= dc_a;
      a_nv_q    <= nv_a;
    end
  end

  // Stage B: product max*d and the saturation limit.
  logic [hca_pkg::MxdW-1:0] mxd_b;
  logic [16:0]              ds_b;
  logic [14:0]              lim_b;
  logic [hca_pkg::PW-1:0]   p_b;

  always_comb begin
    mxd_b = (a_d_q == 8'd0) ? 16'd1 : {8'd0, a_mx_q} * {8'd0, a_d_q};
    ds_b  = {9'd0, a_d_q} * {8'd0, cfg_i.sat};
    lim_b = {7'd0, a_mx_q} * 15'd100;
    p_b   = (ds_b > {2'b00, lim_b}) ? lim_b : ds_b[14:0];
  end

  logic [7:0]               b_alpha_q;
  logic [hca_pkg::MxdW-1:0] b_mxd_q;
  logic [hca_pkg::PW-1:0]   b_p_q;
  logic [NC-1:0][7:0]       b_dc_q;
  logic [hca_pkg::NvW-1:0]  b_nv_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      b_alpha_q <= a_alpha_q;
      b_mxd_q   <= mxd_b;
      b_p_q     <= p_b;
      b_dc_q    <= a_dc_q;
      b_nv_q    <= a_nv_q;
    end
  end

  // Stage C: scaled products.
  logic [hca_pkg::ProdW-1:0]          hm_c;
  logic [NC-1:0][hca_pkg::ProdW-1:0]  pd_c;
  logic [hca_pkg::QW-1:0]             qd_c;

  always_comb begin
    hm_c = {7'd0, b_mxd_q} * 23'd100;
    for (int c = 0; c < NC; c++) begin
      pd_c[c] = {8'd0, b_p_q} * {15'd0, b_dc_q[c]};
    end
    qd_c = {14'd0, b_mxd_q} * 30'd10000;
  end

  logic [7:0]                         c_alpha_q;
  logic [hca_pkg::ProdW-1:0]          c_hm_q;
  logic [NC-1:0][hca_pkg::ProdW-1:0]  c_pd_q;
  logic [hca_pkg::QW-1:0]             c_qd_q;
  logic [hca_pkg::NvW-1:0]            c_nv_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      c_alpha_q <= b_alpha_q;
      c_hm_q    <= hm_c;
      c_pd_q    <= pd_c;
      c_qd_q    <= qd_c;
      c_nv_q    <= b_nv_q;
    end
  end

  // Stage D: channel term.
  logic [7:0]                         d_alpha_q;
  logic [NC-1:0][hca_pkg::ProdW-1:0]  d_t_q;
  logic [hca_pkg::QW-1:0]             d_qd_q;
  logic [hca_pkg::NvW-1:0]            d_nv_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      d_alpha_q <= c_alpha_q;
      for (int c = 0; c < NC; c++) begin
        d_t_q[c] <= c_hm_q - c_pd_q[c];
      end
      d_qd_q    <= c_qd_q;
      d_nv_q    <= c_nv_q;
    end
  end

  // Stage E: numerator.
  logic [7:0]                        e_alpha_q;
  logic [NC-1:0][hca_pkg::NumW-1:0]  e_n_q;
  logic [hca_pkg::QW-1:0]            e_qd_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      e_alpha_q <= d_alpha_q;
      for (int c = 0; c < NC; c++) begin
        e_n_q[c] <= {23'd0, d_nv_q} * {15'd0, d_t_q[c]};
      end
      e_qd_q    <= d_qd_q;
    end
  end

  // Stage F: rounding offset and doubled divisor.
  hca_pkg::div_t f_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      f_q.alpha <= e_alpha_q;
      for (int c = 0; c < NC; c++) begin
        f_q.rem[c] <= {e_n_q[c], 1'b0} + {9'd0, e_qd_q};
      end
      f_q.y    <= {e_qd_q, 1'b0};
      f_q.quot <= '0;
    end
  end

  assign out_item_o = f_q;

endmodule

// ===== hw/rtl/hca_div.sv =====
// ----------------------------------------------------------------------------
// hca_div
// Restoring divider with one quotient bit per pipeline stage for all three
// channels.
// ----------------------------------------------------------------------------
module hca_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hca_pkg::div_t  in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hca_pkg::quot_t out_item_o
);

  localparam int NSt = hca_pkg::DivSteps;
  localparam int NC  = hca_pkg::NumChan;
  localparam int XW  = hca_pkg::XW;
  localparam int YW  = hca_pkg::YW;

  logic [NSt-1:0] vld_q;
  logic [NSt:0]   en;
  hca_pkg::div_t  st_q [NSt];

  always_comb begin
    en[NSt] = out_ready_i;
    for (int i = NSt - 1; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int i = 0; i < NSt; i++) begin
        if (en[i]) begin
          vld_q[i] <= (i == 0) ? in_valid_i : vld_q[i-1];
        end
      end
    end
  end

  for (genvar i = 0; i < NSt; i++) begin : g_step
    localparam int Bit = hca_pkg::QuotW - 1 - i;
    hca_pkg::div_t cur;
    hca_pkg::div_t nxt;
    logic [XW-1:0] sh;

    if (i == 0) begin : g_first
      assign cur = in_item_i;
    end else begin : g_rest
      assign cur = st_q[i-1];
    end

    always_comb begin
      nxt = cur;
      sh  = {{(XW - YW){1'b0}}, cur.y} << Bit;
      for (int c = 0; c < NC; c++) begin
        if (cur.rem[c] >= sh) begin
          nxt.rem[c]       = cur.rem[c] - sh;
          nxt.quot[c][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[i]) begin
        st_q[i] <= nxt;
      end
    end
  end

  assign in_ready_o       = en[0];
  assign out_valid_o      = vld_q[NSt-1];
  assign out_item_o.alpha = st_q[NSt-1].alpha;
  assign out_item_o.chan  = st_q[NSt-1].quot;

endmodule

// ===== hw/rtl/hca_contrast.sv =====
// ----------------------------------------------------------------------------
// hca_contrast
// Four-stage contrast gain about mid-grey with truncation, clamping and the
// output register.
// ----------------------------------------------------------------------------
module hca_contrast (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hca_pkg::cfg_t             cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  hca_pkg::quot_t            in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [hca_pkg::PixW-1:0]  out_pixel_o
);

  localparam int NSt = hca_pkg::ContrastStages;
  localparam int NC  = hca_pkg::NumChan;

  logic [NSt-1:0] vld_q;
  logic [NSt:0]   en;

  always_comb begin
    en[NSt] = out_ready_i;
    for (int i = NSt - 1; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int i = 0; i < NSt; i++) begin
        if (en[i]) begin
          vld_q[i] <= (i == 0) ? in_valid_i : vld_q[i-1];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NSt-1];

  // Stage 1: channel times gain.
  logic [7:0]          s1_alpha_q;
  logic [NC-1:0][15:0] s1_m_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_alpha_q <= in_item_i.alpha;
      for (int c = 0; c < NC; c++) begin
        s1_m_q[c] <= {8'd0, in_item_i.chan[c]} * {8'd0, cfg_i.contrast};
      end
    end
  end

  // Stage 2: bias about mid-grey, negative results give zero.
  logic signed [16:0]        off_2;
  logic signed [17:0]        num_2 [NC];
  logic [NC-1:0][15:0]       u_2;

  always_comb begin
    off_2 = $signed(hca_pkg::ContrastBias) - $signed({2'b00, cfg_i.contrast, 7'd0});
    for (int c = 0; c < NC; c++) begin
      num_2[c] = $signed({2'b00, s1_m_q[c]}) + $signed({off_2[16], off_2});
      u_2[c]   = num_2[c][17] ? 16'd0 : num_2[c][15:0];
    end
  end

  logic [7:0]          s2_alpha_q;
  logic [NC-1:0][15:0] s2_u_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_alpha_q <= s1_alpha_q;
      s2_u_q     <= u_2;
    end
  end

  // Stage 3: reciprocal multiply for the division by one hundred.
  logic [7:0]          s3_alpha_q;
  logic [NC-1:0][28:0] s3_p_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_alpha_q <= s2_alpha_q;
      for (int c = 0; c < NC; c++) begin
        s3_p_q[c] <= {13'd0, s2_u_q[c]} * hca_pkg::Recip100;
      end
    end
  end

  // Stage 4: quotient, clamp and output register.
  logic [NC-1:0][9:0]  qv_4;
  logic [NC-1:0][7:0]  ch_4;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      qv_4[c] = s3_p_q[c][hca_pkg::Recip100Sh +: 10];
      ch_4[c] = (qv_4[c] > {2'b00, hca_pkg::ChanMax}) ? hca_pkg::ChanMax : qv_4[c][7:0];
    end
  end

  logic [hca_pkg::PixW-1:0] s4_pix_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_pix_q <= {s3_alpha_q, ch_4};
    end
  end

  assign out_pixel_o = s4_pix_q;

endmodule

// ===== hw/rtl/hca_checker.sv =====
// ----------------------------------------------------------------------------
// hca_checker
// Port-level checks of the colour adjustment pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module hca_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_o,
  input  logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  input  logic [hca_pkg::PixW-1:0]      m_axis_tdata_o
);

  logic [4:0] pend_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {4'd0, in_xfer} - {4'd0, out_xfer};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("Stalled output transfer changed.");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("Input refused although the output stage is empty.");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pend_q != 5'd0)
    else $error("Result offered with no pixel in flight.");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 5'(hca_pkg::PipeDepth))
    else $error("More pixels in flight than pipeline stages.");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("Result offered during reset.");

endmodule

bind pixel_hsv_color_adjust_top hca_checker u_hca_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
